@@ rtl/gscl_pkg.sv @@
// Package: shared types, constants and sequencer states of the gradient lookup.
package gscl_pkg;

	localparam int DEF_MAX_SEGMENTS  = 16;
	localparam int DEF_TABLE_ENTRIES = 256;
	localparam int POS_W = 20;
	localparam int DIV_NW = 40;
	localparam int DIV_DW = 18;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [3:0]  slot;
		logic [15:0] left_pos;
		logic [15:0] middle_pos;
		logic [15:0] right_pos;
		logic [63:0] left_color;
		logic [63:0] right_color;
		logic [7:0]  position_index;
	} in_word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       error;
	} out_word_t;

	typedef struct packed {
		logic [15:0] left_pos;
		logic [15:0] middle_pos;
		logic [15:0] right_pos;
		logic [63:0] left_color;
		logic [63:0] right_color;
	} seg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_SEL,
		ST_MUL,
		ST_DST,
		ST_DIV,
		ST_CHAN,
		ST_OUT
	} state_t;

endpackage

@@ rtl/gscl_seg_mem.sv @@
// Segment store: one write port, one registered read port.
module gscl_seg_mem #(
	parameter int DEPTH = gscl_pkg::DEF_MAX_SEGMENTS,
	parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic           clk,
	input  logic           we,
	input  logic [IW-1:0]  waddr,
	input  gscl_pkg::seg_t wdata,
	input  logic [IW-1:0]  raddr,
	output gscl_pkg::seg_t rdata
);

	gscl_pkg::seg_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/gscl_div.sv @@
// Signed divider, one quotient bit per cycle, truncating toward zero.
module gscl_div #(
	parameter int NW = gscl_pkg::DIV_NW,
	parameter int DW = gscl_pkg::DIV_DW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic                 done,
	output logic signed [NW-1:0] quot
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] q_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dm_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [DW:0]   rs;
	logic          ge;

	assign rs = {rem_q, q_q[NW-1]};
	assign ge = rs >= {1'b0, dm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num[NW-1] ? NW'(-num) : num;
			dm_q  <= den[DW-1] ? DW'(-den) : den;
			neg_q <= num[NW-1] ^ den[DW-1];
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? DW'(rs - {1'b0, dm_q}) : rs[DW-1:0];
			q_q   <= {q_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? NW'(-q_q) : q_q;

endmodule

@@ rtl/gradient_segment_color_lookup_unit.sv @@
// Top level: segment store, search sequencer and per-channel interpolation.
//
// A load word writes one segment slot in the accept cycle and leaves busy low.
// An evaluate word takes the position from a constant lookup in the accept cycle,
// then reads and checks one segment after another until one covers it, selects
// the half, and per color channel runs one multiply, then the shared bit-serial
// divider with its 40 quotient bits. When no segment covers the position, the
// result carries the error flag. The result is shown for exactly one cycle with
// result_valid, and the receiver cannot hold it off.
module gradient_segment_color_lookup_unit #(
	parameter int MAX_SEGMENTS  = gscl_pkg::DEF_MAX_SEGMENTS,
	parameter int TABLE_ENTRIES = gscl_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  gscl_pkg::in_word_t  item,
	output logic                result_valid,
	output gscl_pkg::out_word_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [4:0]          cfg_data
);

	localparam int IW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int SCW = $clog2(MAX_SEGMENTS + 1) > 5 ? $clog2(MAX_SEGMENTS + 1) : 5;
	localparam int NW  = gscl_pkg::DIV_NW;
	localparam int DW  = gscl_pkg::DIV_DW;
	localparam int PW  = gscl_pkg::POS_W;

	gscl_pkg::state_t state_q, state_d;

	logic [4:0]           seg_count_q;
	logic [SCW-1:0]       idx_q;
	logic [SCW-1:0]       active;
	logic [PW-1:0]        pos_q;
	gscl_pkg::seg_t       seg_q;
	gscl_pkg::seg_t       rdata;
	logic                 low_half_q;
	logic [15:0]          lo_q;
	logic signed [16:0]   wid_q;
	logic [1:0]           ch_q;
	logic signed [37:0]   prod_q;
	gscl_pkg::out_word_t  res_q;

	logic                 accept;
	logic                 mem_we;
	logic [SCW+3:0]       slot_ext;
	logic [PW-1:0]        pos_tab [256];
	logic                 div_start;
	logic signed [NW-1:0] div_num;
	logic signed [DW-1:0] div_den;
	logic                 div_done;
	logic signed [NW-1:0] div_quot;
	logic                 hit;
	logic                 sel_low;
	logic [15:0]          sel_lo;
	logic signed [16:0]   sel_wid;
	logic [15:0]          lc, rc, mc, ca, cb;
	logic [16:0]          csum;
	logic signed [16:0]   diff;
	logic signed [20:0]   dpos;
	logic signed [NW:0]   val;
	logic [24:0]          scaled;
	logic [7:0]           byte_v;

	assign accept   = start && !busy;
	assign slot_ext = (SCW + 4)'(item.slot);
	assign mem_we   = accept && item.cmd == gscl_pkg::CMD_LOAD
		&& slot_ext < (SCW + 4)'(MAX_SEGMENTS);
	assign active   = (SCW'(seg_count_q) < SCW'(MAX_SEGMENTS)) ? SCW'(seg_count_q)
		: SCW'(MAX_SEGMENTS);

	for (genvar gi = 0; gi < 256; gi++) begin : g_pos
		assign pos_tab[gi] = PW'((gi * 32768) / TABLE_ENTRIES);
	end

	gscl_seg_mem #(.DEPTH(MAX_SEGMENTS), .IW(IW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot_ext[IW-1:0]),
		.wdata ({item.left_pos, item.middle_pos, item.right_pos,
			item.left_color, item.right_color}),
		.raddr (idx_q[IW-1:0]),
		.rdata (rdata)
	);

	assign div_num = NW'(prod_q);
	assign div_den = DW'(wid_q);

	gscl_div #(.NW(NW), .DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign hit     = PW'(rdata.right_pos) >= pos_q;
	assign sel_low = pos_q < PW'(seg_q.middle_pos);
	assign sel_lo  = sel_low ? seg_q.left_pos : seg_q.middle_pos;
	assign sel_wid = sel_low ? 17'(seg_q.middle_pos) - 17'(seg_q.left_pos)
		: 17'(seg_q.right_pos) - 17'(seg_q.middle_pos);

	assign lc     = seg_q.left_color[16*ch_q +: 16];
	assign rc     = seg_q.right_color[16*ch_q +: 16];
	assign csum   = 17'(lc) + 17'(rc);
	assign mc     = csum[16:1];
	assign ca     = low_half_q ? lc : mc;
	assign cb     = low_half_q ? mc : rc;
	assign diff   = 17'(cb) - 17'(ca);
	assign dpos   = 21'(pos_q) - 21'(lo_q);
	assign val    = (NW + 1)'(ca) + (NW + 1)'(div_quot);
	assign scaled = 25'(val[16:0]) * 25'd255;

	always_comb begin
		if (val < 0) begin
			byte_v = 8'd0;
		end else if (val >= (NW + 1)'(32897)) begin
			byte_v = 8'd255;
		end else begin
			byte_v = scaled[22:15];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gscl_pkg::ST_IDLE: begin
				if (start && item.cmd == gscl_pkg::CMD_EVAL) begin
					state_d = gscl_pkg::ST_RD;
				end
			end
			gscl_pkg::ST_RD: begin
				state_d = (idx_q < active) ? gscl_pkg::ST_CHK : gscl_pkg::ST_OUT;
			end
			gscl_pkg::ST_CHK: begin
				state_d = hit ? gscl_pkg::ST_SEL : gscl_pkg::ST_RD;
			end
			gscl_pkg::ST_SEL: begin
				state_d = (sel_wid == 0) ? gscl_pkg::ST_OUT : gscl_pkg::ST_MUL;
			end
			gscl_pkg::ST_MUL:  state_d = gscl_pkg::ST_DST;
			gscl_pkg::ST_DST:  state_d = gscl_pkg::ST_DIV;
			gscl_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = gscl_pkg::ST_CHAN;
				end
			end
			gscl_pkg::ST_CHAN: begin
				state_d = (ch_q == 2'd3) ? gscl_pkg::ST_OUT : gscl_pkg::ST_MUL;
			end
			gscl_pkg::ST_OUT:  state_d = gscl_pkg::ST_IDLE;
			default:           state_d = gscl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy         = state_q != gscl_pkg::ST_IDLE;
		result_valid = state_q == gscl_pkg::ST_OUT;
		div_start    = state_q == gscl_pkg::ST_DST;
		cfg_ready    = state_q == gscl_pkg::ST_IDLE;
	end

	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gscl_pkg::ST_IDLE;
			seg_count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				seg_count_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gscl_pkg::ST_IDLE: begin
				res_q <= '0;
				idx_q <= '0;
				if (accept && item.cmd == gscl_pkg::CMD_EVAL) begin
					pos_q <= pos_tab[item.position_index];
				end
			end
			gscl_pkg::ST_RD: begin
				if (idx_q >= active) begin
					res_q.error <= 1'b1;
				end
			end
			gscl_pkg::ST_CHK: begin
				if (hit) begin
					seg_q <= rdata;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			gscl_pkg::ST_SEL: begin
				low_half_q <= sel_low;
				lo_q       <= sel_lo;
				wid_q      <= sel_wid;
				ch_q       <= 2'd0;
				if (sel_wid == 0) begin
					res_q.error <= 1'b1;
				end
			end
			gscl_pkg::ST_MUL: begin
				prod_q <= 38'(diff) * 38'(dpos);
			end
			gscl_pkg::ST_CHAN: begin
				case (ch_q)
					2'd0:    res_q.red   <= byte_v;
					2'd1:    res_q.green <= byte_v;
					2'd2:    res_q.blue  <= byte_v;
					default: res_q.alpha <= byte_v;
				endcase
				ch_q <= ch_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.error |-> result.red == 8'd0 && result.green == 8'd0
			&& result.blue == 8'd0 && result.alpha == 8'd0)
		else $error("error result carries nonzero channels");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.cmd == gscl_pkg::CMD_EVAL |=> busy)
		else $error("evaluate word did not start the sequencer");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.cmd == gscl_pkg::CMD_LOAD |=> !busy && !result_valid)
		else $error("load word produced activity");

endmodule
